// File: sv/route_quality_scorer_defines.svh
// Assertion macros shared by the route quality scorer RTL.
`ifndef ROUTE_QUALITY_SCORER_DEFINES_SVH
`define ROUTE_QUALITY_SCORER_DEFINES_SVH

// same-cycle implication
`define RQS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rqs_pkg.sv
// Types and constants of the route quality scorer.
`default_nettype none
package rqs_pkg;
	localparam int NUM_W = 31;
	localparam int DEN_W = 16;
	localparam int QUO_W = 15;
	localparam int DIV_STAGES = QUO_W + 1;

	localparam logic [14:0] FULL_SCORE = 15'd25600;
	localparam logic [15:0] FULL_CONF = 16'd32768;

	localparam logic [2:0] REG_IDEAL_RTT = 3'd0;
	localparam logic [2:0] REG_MAX_RTT = 3'd1;
	localparam logic [2:0] REG_MAX_JITTER = 3'd2;
	localparam logic [2:0] REG_MAX_LOSS = 3'd3;
	localparam logic [2:0] REG_CONF_SAMPLES = 3'd4;
	localparam logic [2:0] REG_WEIGHTS = 3'd5;
	localparam logic [2:0] REG_THRESHOLDS = 3'd6;

	localparam logic [1:0] HEALTH_UNKNOWN = 2'd0;
	localparam logic [1:0] HEALTH_HEALTHY = 2'd1;
	localparam logic [1:0] HEALTH_DEGRADED = 2'd2;
	localparam logic [1:0] HEALTH_OFFLINE = 2'd3;

	localparam logic [2:0] GRADE_NONE = 3'd0;
	localparam logic [2:0] GRADE_EXCELLENT = 3'd1;
	localparam logic [2:0] GRADE_GOOD = 3'd2;
	localparam logic [2:0] GRADE_UNSTABLE = 3'd3;
	localparam logic [2:0] GRADE_POOR = 3'd4;
	localparam logic [2:0] GRADE_OFFLINE = 3'd5;

	typedef struct packed {
		logic        no_samples;
		logic        offline;
		logic        rtt_full;
		logic        rtt_zero;
		logic        jit_zero;
		logic        loss_zero;
		logic        conf_full;
		logic [14:0] stab;
	} side_t;
endpackage
`default_nettype wire

// File: sv/rqs_div.sv
// Pipelined restoring divider: a load stage, then one quotient bit per stage.
`default_nettype none
module rqs_div (
	input  wire logic                      clk,
	input  wire logic                      en,
	input  wire logic [rqs_pkg::NUM_W-1:0] num,
	input  wire logic [rqs_pkg::DEN_W-1:0] den,
	output logic      [rqs_pkg::QUO_W-1:0] quo
);
	import rqs_pkg::*;

	logic [NUM_W-1:0] rem_s [DIV_STAGES];
	logic [DEN_W-1:0] den_s [DIV_STAGES];
	logic [QUO_W-1:0] quo_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
		end
	end

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
		localparam int B = QUO_W - k;
		logic [NUM_W:0] shifted;
		logic [NUM_W:0] diff;
		assign shifted = {{(NUM_W + 1 - DEN_W){1'b0}}, den_s[k-1]} << B;
		assign diff = {1'b0, rem_s[k-1]} - shifted;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= den_s[k-1];
				if (!diff[NUM_W]) begin
					rem_s[k] <= diff[NUM_W-1:0];
					quo_s[k] <= quo_s[k-1] | (QUO_W'(1) << B);
				end else begin
					rem_s[k] <= rem_s[k-1];
					quo_s[k] <= quo_s[k-1];
				end
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];
endmodule
`default_nettype wire

// File: sv/route_quality_scorer.sv
// Route quality scorer: per-item RTT, jitter, loss, stability and confidence scoring.
// Channels: s_axis carries one route-metrics item per transfer, m_axis one result per
// item, in order. cfg_* writes one register per transfer (index 0..6, others ignored);
// cfg_ready is always high. Write configuration only while no item is in flight.
// Pipeline: the 16-stage bit-serial divider pipelines (a load stage, then one quotient
// bit per stage) plus input, product, sum and grade stages. Throughput: one item per
// cycle while no result waits on m_tready.
// The whole pipeline advances whenever the output register is empty or taken; while
// the receiver holds m_tready low with a result waiting, every stage freezes and
// s_tready drops, so nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits and loads the registers' default values.
`default_nettype none
`include "route_quality_scorer_defines.svh"
module route_quality_scorer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// rtt_avg[15:0], jitter[31:16], loss_pct[46:32], stability_in[62:47],
	// sample_count[78:63]
	input  wire logic [79:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// quality_score[14:0], confidence[30:15], health[32:31], grade[35:33]
	output logic      [39:0] m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [44:0] cfg_data
);
	import rqs_pkg::*;

	logic [15:0] ideal_rtt_q, max_rtt_q, max_jitter_q, conf_samples_q;
	logic [14:0] max_loss_q;
	logic [35:0] weights_q;
	logic [44:0] thresholds_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ideal_rtt_q <= 16'd800;
			max_rtt_q <= 16'd8000;
			max_jitter_q <= 16'd1600;
			max_loss_q <= 15'd2560;
			conf_samples_q <= 16'd10;
			weights_q <= 36'd8606744640;
			thresholds_q <= 45'd10995619614720;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IDEAL_RTT: ideal_rtt_q <= cfg_data[15:0];
				REG_MAX_RTT: max_rtt_q <= cfg_data[15:0];
				REG_MAX_JITTER: max_jitter_q <= cfg_data[15:0];
				REG_MAX_LOSS: max_loss_q <= cfg_data[14:0];
				REG_CONF_SAMPLES: conf_samples_q <= cfg_data[15:0];
				REG_WEIGHTS: weights_q <= cfg_data[35:0];
				REG_THRESHOLDS: thresholds_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic adv;
	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv;

	// input decode
	logic [15:0] rtt_in, jit_in, stab_in, smp_in;
	logic [14:0] loss_in;
	assign rtt_in = s_tdata[15:0];
	assign jit_in = s_tdata[31:16];
	assign loss_in = s_tdata[46:32];
	assign stab_in = s_tdata[62:47];
	assign smp_in = s_tdata[78:63];

	// stage 1: flags, differences, stability
	logic        v_s1;
	side_t       side_s1;
	logic [15:0] rtt_dn_s1, rtt_dd_s1, jit_dn_s1, smp_s1;
	logic [14:0] loss_dn_s1;

	logic [21:0] penalty;
	logic [14:0] stab_c;
	always_comb begin
		penalty = {1'b0, jit_in, 5'd0} + {4'd0, loss_in, 3'd0};
		if (stab_in != 16'd0)
			stab_c = (stab_in > {1'b0, FULL_SCORE}) ? FULL_SCORE : stab_in[14:0];
		else if (penalty >= {7'd0, FULL_SCORE})
			stab_c = '0;
		else
			stab_c = FULL_SCORE - penalty[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.no_samples <= smp_in == 16'd0;
			side_s1.offline <= loss_in >= FULL_SCORE;
			side_s1.rtt_full <= rtt_in <= ideal_rtt_q;
			side_s1.rtt_zero <= max_rtt_q <= ideal_rtt_q || rtt_in >= max_rtt_q;
			side_s1.jit_zero <= max_jitter_q == 16'd0 || jit_in >= max_jitter_q;
			side_s1.loss_zero <= max_loss_q == 15'd0 || loss_in >= max_loss_q;
			side_s1.conf_full <= conf_samples_q == 16'd0 || smp_in >= conf_samples_q;
			side_s1.stab <= stab_c;
			rtt_dn_s1 <= max_rtt_q - rtt_in;
			rtt_dd_s1 <= max_rtt_q - ideal_rtt_q;
			jit_dn_s1 <= max_jitter_q - jit_in;
			loss_dn_s1 <= max_loss_q - loss_in;
			smp_s1 <= smp_in;
		end
	end

	// divider stages
	logic [NUM_W-1:0] rtt_num, jit_num, loss_num, conf_num;
	assign rtt_num = NUM_W'(rtt_dn_s1) * NUM_W'(FULL_SCORE);
	assign jit_num = NUM_W'(jit_dn_s1) * NUM_W'(FULL_SCORE);
	assign loss_num = NUM_W'(loss_dn_s1) * NUM_W'(FULL_SCORE);
	assign conf_num = NUM_W'(smp_s1) << 15;

	logic [QUO_W-1:0] rtt_q, jit_q, loss_q, conf_q;

	rqs_div u_div_rtt (.clk, .en(adv), .num(rtt_num), .den(rtt_dd_s1), .quo(rtt_q));
	rqs_div u_div_jit (.clk, .en(adv), .num(jit_num), .den(max_jitter_q),
		.quo(jit_q));
	rqs_div u_div_loss (.clk, .en(adv), .num(loss_num), .den({1'b0, max_loss_q}),
		.quo(loss_q));
	rqs_div u_div_conf (.clk, .en(adv), .num(conf_num), .den(conf_samples_q),
		.quo(conf_q));

	side_t side_s2 [DIV_STAGES];
	logic [DIV_STAGES-1:0] v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= '0;
		else if (adv) v_s2 <= {v_s2[DIV_STAGES-2:0], v_s1};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2[0] <= side_s1;
			for (int k = 1; k < DIV_STAGES; k++) side_s2[k] <= side_s2[k-1];
		end
	end

	side_t side_d;
	assign side_d = side_s2[DIV_STAGES-1];

	// stage 3: term scores times weights
	logic [14:0] s_rtt, s_jit, s_loss;
	logic [15:0] conf_c;
	assign s_rtt = side_d.rtt_full ? FULL_SCORE : (side_d.rtt_zero ? '0 : rtt_q);
	assign s_jit = side_d.jit_zero ? '0 : jit_q;
	assign s_loss = side_d.loss_zero ? '0 : loss_q;
	assign conf_c = side_d.conf_full ? FULL_CONF : {1'b0, conf_q};

	logic        v_s3;
	logic [23:0] p_rtt_s3, p_jit_s3, p_loss_s3, p_stab_s3;
	logic [15:0] conf_s3;
	logic        nos_s3, off_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_rtt_s3 <= 24'(s_rtt) * 24'(weights_q[8:0]);
			p_jit_s3 <= 24'(s_jit) * 24'(weights_q[17:9]);
			p_loss_s3 <= 24'(s_loss) * 24'(weights_q[26:18]);
			p_stab_s3 <= 24'(side_d.stab) * 24'(weights_q[35:27]);
			conf_s3 <= conf_c;
			nos_s3 <= side_d.no_samples;
			off_s3 <= side_d.offline;
		end
	end

	// stage 4: sum and clamp
	logic [25:0] sum;
	logic [14:0] q_c;
	assign sum = 26'(p_rtt_s3) + 26'(p_jit_s3) + 26'(p_loss_s3) + 26'(p_stab_s3);
	assign q_c = (sum[25:8] > 18'(FULL_SCORE)) ? FULL_SCORE : sum[22:8];

	logic        v_s4, nos_s4, off_s4;
	logic [14:0] q_s4;
	logic [15:0] conf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s4 <= nos_s3 ? '0 : q_c;
			conf_s4 <= nos_s3 ? '0 : conf_s3;
			nos_s4 <= nos_s3;
			off_s4 <= off_s3;
		end
	end

	// stage 5: grading, output register
	logic [1:0] health_c;
	logic [2:0] grade_c;
	always_comb begin
		if (off_s4) begin
			health_c = HEALTH_OFFLINE;
			grade_c = GRADE_OFFLINE;
		end else if (nos_s4) begin
			health_c = HEALTH_UNKNOWN;
			grade_c = GRADE_NONE;
		end else if (q_s4 >= thresholds_q[14:0]) begin
			health_c = HEALTH_HEALTHY;
			grade_c = GRADE_EXCELLENT;
		end else if (q_s4 >= thresholds_q[29:15]) begin
			health_c = HEALTH_HEALTHY;
			grade_c = GRADE_GOOD;
		end else if (q_s4 >= thresholds_q[44:30]) begin
			health_c = HEALTH_DEGRADED;
			grade_c = GRADE_UNSTABLE;
		end else begin
			health_c = HEALTH_OFFLINE;
			grade_c = GRADE_POOR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (adv) m_tvalid <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) m_tdata <= {4'd0, grade_c, health_c, conf_s4, q_s4};
	end

	`RQS_ASSERT_IMPL(a_score_range, clk, arst_n, m_tvalid, m_tdata[14:0] <= FULL_SCORE,
		"quality score above full scale")
	`RQS_ASSERT_IMPL(a_conf_range, clk, arst_n, m_tvalid, m_tdata[30:15] <= FULL_CONF,
		"confidence above one")
	`RQS_ASSERT_IMPL(a_none_zero, clk, arst_n, m_tvalid && m_tdata[35:33] == GRADE_NONE,
		m_tdata[14:0] == 15'd0 && m_tdata[30:15] == 16'd0, "ungraded result with score")
	`RQS_ASSERT_IMPL(a_offline_health, clk, arst_n,
		m_tvalid && (m_tdata[35:33] == GRADE_OFFLINE || m_tdata[35:33] == GRADE_POOR),
		m_tdata[32:31] == HEALTH_OFFLINE, "poor or offline grade without offline health")
endmodule
`default_nettype wire
